FILE: design/mbp_pkg.sv
package mbp_pkg;

  localparam int MAX_CODE_BITS = 32;
  localparam int IN_VALUE_W    = 32;
  localparam int IN_LEN_W      = 6;
  localparam int BYTE_W        = 8;
  localparam int BYTE_LAST_BIT = 7;

  localparam int LEN_W = $clog2(MAX_CODE_BITS + 1);
  localparam int BUF_W = MAX_CODE_BITS + BYTE_W;
  localparam int CNT_W = $clog2(BUF_W + 1);

  localparam int Q_DEPTH = 2;
  localparam int PTR_W   = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int QCNT_W  = $clog2(Q_DEPTH + 1);

  typedef struct packed {
    logic [MAX_CODE_BITS-1:0] value;
    logic [LEN_W-1:0]         len;
    logic                     flush;
  } item_t;

endpackage

FILE: design/mbp_in_if.sv
interface mbp_in_if;
  logic                             valid;
  logic                             ready;
  logic [mbp_pkg::IN_VALUE_W-1:0]   code_value;
  logic [mbp_pkg::IN_LEN_W-1:0]     code_length;
  logic                             flush;

  modport source (output valid, output code_value, output code_length, output flush,
                  input ready);
  modport sink   (input valid, input code_value, input code_length, input flush,
                  output ready);
endinterface

FILE: design/mbp_out_if.sv
interface mbp_out_if;
  logic                         valid;
  logic                         ready;
  logic [mbp_pkg::BYTE_W-1:0]   out_byte;
  logic                         is_last;

  modport source (output valid, output out_byte, output is_last, input ready);
  modport sink   (input valid, input out_byte, input is_last, output ready);
endinterface

FILE: design/mbp_front.sv
module mbp_front (
  mbp_in_if.sink          in_i,
  output logic            push_valid_o,
  output mbp_pkg::item_t  push_item_o,
  input  logic            push_ready_i
);
  import mbp_pkg::*;

  logic [IN_VALUE_W+MAX_CODE_BITS-1:0] wide_value;
  logic [LEN_W-1:0]                    len_sat;

  assign wide_value = {{MAX_CODE_BITS{1'b0}}, in_i.code_value};

  // saturate the length, then keep only the bits that will be appended
  always_comb begin
    if (int'(in_i.code_length) > MAX_CODE_BITS) begin
      len_sat = LEN_W'(MAX_CODE_BITS);
    end else begin
      len_sat = LEN_W'(in_i.code_length);
    end
    for (int i = 0; i < MAX_CODE_BITS; i++) begin
      push_item_o.value[i] = (i < int'(len_sat)) ? wide_value[i] : 1'b0;
    end
    push_item_o.len   = len_sat;
    push_item_o.flush = in_i.flush;
  end

  assign push_valid_o      = in_i.valid;
  assign in_i.ready        = push_ready_i;

endmodule

FILE: design/mbp_queue.sv
module mbp_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_valid_i,
  input  mbp_pkg::item_t  push_item_i,
  output logic            push_ready_o,
  output logic            pop_valid_o,
  output mbp_pkg::item_t  pop_item_o,
  input  logic            pop_i
);
  import mbp_pkg::*;

  item_t             mem_q [Q_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0]  rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] count_q, count_d;
  logic              push;

  assign push_ready_o = (count_q != QCNT_W'(Q_DEPTH));
  assign push         = push_valid_i && push_ready_o;
  assign pop_valid_o  = (count_q != '0);
  assign pop_item_o   = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (!push && pop_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

FILE: design/mbp_back.sv
module mbp_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            item_valid_i,
  input  mbp_pkg::item_t  item_i,
  output logic            pop_o,
  mbp_out_if.source       out_o
);
  import mbp_pkg::*;

  logic [BUF_W-1:0]  buf_q, buf_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              flush_q, flush_d;
  logic              active_q, active_d;
  logic              ovld_q, ovld_d;
  logic [BYTE_W-1:0] byte_q, byte_d;
  logic              last_q, last_d;

  logic              emit_ok, fire, rem_need, can_load, new_need;
  logic [BYTE_W-1:0] e_byte;
  logic              e_last;
  logic [BUF_W-1:0]  rem_buf, base_buf, new_buf;
  logic [CNT_W-1:0]  rem_cnt, base_cnt, new_cnt, shamt;

  assign emit_ok = !ovld_q || out_o.ready;
  assign fire    = active_q && emit_ok;
  assign e_byte  = buf_q[BUF_W-1 -: BYTE_W];

  // a full byte if there is one, otherwise the zero padded flush byte
  always_comb begin
    if (cnt_q >= CNT_W'(BYTE_W)) begin
      e_last  = flush_q && (cnt_q == CNT_W'(BYTE_W));
      rem_cnt = cnt_q - CNT_W'(BYTE_W);
      rem_buf = buf_q << BYTE_W;
    end else begin
      e_last  = 1'b1;
      rem_cnt = '0;
      rem_buf = '0;
    end
  end

  assign rem_need = (rem_cnt >= CNT_W'(BYTE_W)) || (flush_q && (rem_cnt != '0));
  assign can_load = !active_q || (fire && !rem_need);
  assign pop_o    = can_load && item_valid_i;

  assign base_cnt = fire ? rem_cnt : cnt_q;
  assign base_buf = fire ? rem_buf : buf_q;

  // new code lands just below the pending bits
  assign shamt    = CNT_W'(BUF_W) - base_cnt - CNT_W'(item_i.len);
  assign new_buf  = base_buf | (BUF_W'(item_i.value) << shamt);
  assign new_cnt  = base_cnt + CNT_W'(item_i.len);
  assign new_need = (new_cnt >= CNT_W'(BYTE_W)) || (item_i.flush && (new_cnt != '0));

  always_comb begin
    buf_d    = buf_q;
    cnt_d    = cnt_q;
    flush_d  = flush_q;
    active_d = active_q;
    ovld_d   = ovld_q;
    byte_d   = byte_q;
    last_d   = last_q;
    if (pop_o) begin
      buf_d    = new_buf;
      cnt_d    = new_cnt;
      flush_d  = item_i.flush;
      active_d = new_need;
    end else if (fire) begin
      buf_d    = rem_buf;
      cnt_d    = rem_cnt;
      active_d = rem_need;
    end
    if (fire) begin
      ovld_d = 1'b1;
      byte_d = e_byte;
      last_d = e_last;
    end else if (out_o.ready) begin
      ovld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      buf_q    <= '0;
      cnt_q    <= '0;
      flush_q  <= 1'b0;
      active_q <= 1'b0;
      ovld_q   <= 1'b0;
      byte_q   <= '0;
      last_q   <= 1'b0;
    end else begin
      buf_q    <= buf_d;
      cnt_q    <= cnt_d;
      flush_q  <= flush_d;
      active_q <= active_d;
      ovld_q   <= ovld_d;
      byte_q   <= byte_d;
      last_q   <= last_d;
    end
  end

  assign out_o.valid    = ovld_q;
  assign out_o.out_byte = byte_q;
  assign out_o.is_last  = last_q;

  a_active_has_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    active_q |-> ((cnt_q >= CNT_W'(BYTE_W)) || (flush_q && (cnt_q != '0))))
    else $error("active without a byte to emit");

  a_idle_partial: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !active_q |-> ((cnt_q < CNT_W'(BYTE_W)) && !(flush_q && (cnt_q != '0))))
    else $error("idle with undelivered bits");

  a_low_bits_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (buf_q << cnt_q) == '0)
    else $error("stale bits below the pending bits");

  a_pop_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |-> (item_valid_i && (!active_q || (fire && !rem_need))))
    else $error("transaction popped while busy");

  a_fire_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |=> ovld_q)
    else $error("emitted byte not presented");

endmodule

FILE: design/msb_first_bit_packer.sv
// Packs codes of 0 to 32 bits into bytes, earliest bit in bit 7. An input
// transaction is taken every cycle while the two-entry queue behind the input
// has room; the packing stage drains the queue at one byte per cycle, while the
// receiver is ready, through a single output register. A code completes up to
// five bytes (including the padded flush byte), for a 32-bit code with seven
// bits pending and flush set. A flush with no pending bits and no completed
// byte gives no output; otherwise the final byte of a flush transaction carries
// is_last. Pending bits are zero after reset.
module msb_first_bit_packer (
  input  logic      clk_i,
  input  logic      rst_ni,
  mbp_in_if.sink    in_i,
  mbp_out_if.source out_o
);
  import mbp_pkg::*;

  logic  push_valid, push_ready;
  item_t push_item;
  logic  q_valid, pop;
  item_t q_item;

  mbp_front u_front (
    .in_i         (in_i),
    .push_valid_o (push_valid),
    .push_item_o  (push_item),
    .push_ready_i (push_ready)
  );

  mbp_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_item_i  (push_item),
    .push_ready_o (push_ready),
    .pop_valid_o  (q_valid),
    .pop_item_o   (q_item),
    .pop_i        (pop)
  );

  mbp_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (q_valid),
    .item_i       (q_item),
    .pop_o        (pop),
    .out_o        (out_o)
  );

endmodule

FILE: tb/sv/tb.sv
`timescale 1ns / 100ps

module tb;

  import mbp_pkg::*;

  localparam int IDLE_LIMIT = 5000;
  localparam int DRAIN_CYCLES = 12;

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              last;
  } packed_byte_t;

  logic clk_i;
  logic rst_ni;

  mbp_in_if  code_if ();
  mbp_out_if byte_if ();

  msb_first_bit_packer i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (code_if),
    .out_o (byte_if)
  );

  packed_byte_t             packed_bytes_q[$];
  logic [BYTE_LAST_BIT-1:0] held_bits;
  int unsigned              held_cnt;
  int                       err_cnt = 0;
  int                       idle_cycles = 0;
  int                       tx_gap_pct;
  int                       rx_stall_pct;

  initial begin
    clk_i = 1'b0;
  end

  always #1 clk_i = ~clk_i;

  // bit-serial packing of one accepted code into the expected byte stream
  function automatic void pack_code(input logic [IN_VALUE_W-1:0] value,
                                    input logic [IN_LEN_W-1:0] len, input logic flush);
    logic [BYTE_W-1:0] acc;
    int unsigned       cnt;
    int unsigned       nbits;
    int                made;
    logic              bit_in;
    acc   = {1'b0, held_bits};
    cnt   = held_cnt;
    made  = 0;
    nbits = (len > MAX_CODE_BITS) ? MAX_CODE_BITS : len;
    for (int i = int'(nbits) - 1; i >= 0; i--) begin
      bit_in = (i < IN_VALUE_W) ? value[i] : 1'b0;
      acc    = {acc[BYTE_W-2:0], bit_in};
      cnt++;
      if (cnt == BYTE_W) begin
        packed_bytes_q.push_back('{data: acc, last: 1'b0});
        made++;
        acc = '0;
        cnt = 0;
      end
    end
    if (flush) begin
      if (cnt > 0) begin
        packed_bytes_q.push_back('{data: acc << (BYTE_W - cnt), last: 1'b1});
        acc = '0;
        cnt = 0;
      end else if (made > 0) begin
        packed_bytes_q[packed_bytes_q.size() - 1].last = 1'b1;
      end
    end
    held_bits = acc[BYTE_LAST_BIT-1:0];
    held_cnt  = cnt;
  endfunction

  task automatic send_code(input logic [IN_VALUE_W-1:0] value,
                           input logic [IN_LEN_W-1:0] len, input logic flush);
    while ($urandom_range(0, 99) < tx_gap_pct) begin
      code_if.valid = 1'b0;
      @(negedge clk_i);
    end
    code_if.valid       = 1'b1;
    code_if.code_value  = value;
    code_if.code_length = len;
    code_if.flush       = flush;
    forever begin
      @(posedge clk_i);
      if (code_if.ready) break;
    end
    pack_code(value, len, flush);
    @(negedge clk_i);
  endtask

  // receiver back-pressure
  always @(negedge clk_i) begin
    byte_if.ready = ($urandom_range(0, 99) >= rx_stall_pct);
  end

  // result check and watchdog
  always @(posedge clk_i) begin
    packed_byte_t exp_b;
    if (rst_ni) begin
      if ((code_if.valid && code_if.ready) || (byte_if.valid && byte_if.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (byte_if.valid && byte_if.ready) begin
        if (packed_bytes_q.size() == 0) begin
          $error("unexpected transaction: out_byte %02h is_last %0b",
                 byte_if.out_byte, byte_if.is_last);
          err_cnt++;
        end else begin
          exp_b = packed_bytes_q.pop_front();
          if (byte_if.out_byte !== exp_b.data) begin
            $error("out_byte: expected %02h, actual %02h", exp_b.data, byte_if.out_byte);
            err_cnt++;
          end
          if (byte_if.is_last !== exp_b.last) begin
            $error("is_last: expected %0b, actual %0b", exp_b.last, byte_if.is_last);
            err_cnt++;
          end
        end
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("FAILED: results differ");
        $finish;
      end
    end
  end

  task automatic test_edge_codes();
    send_code(32'h0000_0000, 6'd0, 1'b0);
    send_code(32'hFFFF_FFFF, 6'd0, 1'b0);
    send_code(32'hFFFF_FFFF, 6'd32, 1'b0);
    send_code(32'h0000_0000, 6'd32, 1'b0);
    send_code(32'hA5C3_0F96, 6'd32, 1'b0);
    send_code(32'hFFFF_FFFE, 6'd1, 1'b0);
    send_code(32'h0000_0001, 6'd7, 1'b0);
    // lengths past the limit saturate
    send_code(32'h8000_0001, 6'd33, 1'b0);
    send_code(32'hFFFF_FFFF, 6'd63, 1'b0);
    send_code(32'h1234_5678, 6'd40, 1'b0);
    send_code(32'h0000_0055, 6'd8, 1'b0);
  endtask

  task automatic test_flush_cases();
    // nothing pending, nothing completed
    send_code(32'h0000_0000, 6'd0, 1'b1);
    send_code(32'hDEAD_BEEF, 6'd0, 1'b1);
    // partial byte padded
    send_code(32'h0000_0005, 6'd3, 1'b1);
    // exact byte boundary, last lands on the completed byte
    send_code(32'h0000_00C3, 6'd8, 1'b1);
    send_code(32'hCAFE_F00D, 6'd32, 1'b1);
    // seven pending plus a full code gives five bytes
    send_code(32'h0000_007F, 6'd7, 1'b0);
    send_code(32'hFFFF_FFFF, 6'd32, 1'b1);
    send_code(32'h0000_0001, 6'd1, 1'b0);
    send_code(32'h0000_0000, 6'd0, 1'b1);
    send_code(32'h0000_0003, 6'd7, 1'b0);
    send_code(32'h8765_4321, 6'd63, 1'b1);
    send_code(32'h0000_0001, 6'd1, 1'b1);
  endtask

  task automatic test_random_stream(input int n_items, input int gap_pct, input int stall_pct);
    logic [IN_VALUE_W-1:0] value;
    logic [IN_LEN_W-1:0]   len;
    logic                  flush;
    int                    pick;
    tx_gap_pct   = gap_pct;
    rx_stall_pct = stall_pct;
    for (int k = 0; k < n_items; k++) begin
      value = $urandom;
      pick  = $urandom_range(0, 99);
      if (pick < 8) begin
        len = '0;
      end else if (pick < 18) begin
        len = IN_LEN_W'($urandom_range(MAX_CODE_BITS + 1, (1 << IN_LEN_W) - 1));
      end else if (pick < 30) begin
        len = IN_LEN_W'(MAX_CODE_BITS);
      end else begin
        len = IN_LEN_W'($urandom_range(1, MAX_CODE_BITS));
      end
      flush = ($urandom_range(0, 99) < 20);
      send_code(value, len, flush);
    end
  endtask

  initial begin
    held_bits           = '0;
    held_cnt            = 0;
    tx_gap_pct          = 0;
    rx_stall_pct        = 0;
    rst_ni              = 1'b0;
    code_if.valid       = 1'b0;
    code_if.code_value  = '0;
    code_if.code_length = '0;
    code_if.flush       = 1'b0;
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_edge_codes();
    test_flush_cases();
    test_random_stream(160, 14, 71);
    test_random_stream(160, 71, 14);
    test_random_stream(160, 0, 0);

    code_if.valid = 1'b0;
    while (packed_bytes_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (err_cnt == 0 && packed_bytes_q.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
